// ===== hdl/nppc_pkg.sv =====
// Shared constants, types and the default colour table of the nearest palette colour matcher.
// Depends on nothing; every other file of the block imports it.
package nppc_pkg;

  localparam int PAL_CAP    = 256;
  localparam int IDX_W      = $clog2(PAL_CAP);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DEF_COUNT  = 56;
  localparam int DEF_W      = $clog2(DEF_COUNT);
  localparam int RGB_W      = 24;
  localparam int CH_W       = 8;
  localparam int DIST_W     = 10;
  localparam int TOL_W      = 10;
  localparam int PCT_W      = 7;
  localparam int GRAY_STEPS = 16;

  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 3);

  localparam logic [1:0] ACT_FIND = 2'd0;
  localparam logic [1:0] ACT_GRAY = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] CFG_TOL   = 2'd0;
  localparam logic [1:0] CFG_BLACK = 2'd1;
  localparam logic [1:0] CFG_WHITE = 2'd2;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [RGB_W-1:0] wr_data;
  } store_req_t;

  function automatic logic [RGB_W-1:0] default_color(input logic [DEF_W-1:0] i);
    logic [RGB_W-1:0] c;
    case (i)
      6'd0:  c = 24'hFFFFFF;
      6'd1:  c = 24'h000000;
      6'd2:  c = 24'hFF0000;
      6'd3:  c = 24'h00FF00;
      6'd4:  c = 24'h0000FF;
      6'd5:  c = 24'hFFFF00;
      6'd6:  c = 24'hFF00FF;
      6'd7:  c = 24'h00FFFF;
      6'd8:  c = 24'h800000;
      6'd9:  c = 24'h008000;
      6'd10: c = 24'h000080;
      6'd11: c = 24'h808000;
      6'd12: c = 24'h800080;
      6'd13: c = 24'h008080;
      6'd14: c = 24'h4169E1;
      6'd15: c = 24'h00BFFF;
      6'd16: c = 24'h7DCEFA;
      6'd17: c = 24'h4682B4;
      6'd18: c = 24'hB0E0E6;
      6'd19: c = 24'h7FFFD4;
      6'd20: c = 24'h2E8B57;
      6'd21: c = 24'h98FB98;
      6'd22: c = 24'h7CFC00;
      6'd23: c = 24'h32CD32;
      6'd24: c = 24'h228B22;
      6'd25: c = 24'hFFD700;
      6'd26: c = 24'hBC8F8F;
      6'd27: c = 24'h8B4513;
      6'd28: c = 24'hF5F5DC;
      6'd29: c = 24'hD2B48C;
      6'd30: c = 24'hD2691E;
      6'd31: c = 24'hA52A2A;
      6'd32: c = 24'hFFA500;
      6'd33: c = 24'hFF7F50;
      6'd34: c = 24'hFF6347;
      6'd35: c = 24'hFF69B4;
      6'd36: c = 24'hFFC0CB;
      6'd37: c = 24'hB03060;
      6'd38: c = 24'hEE82EE;
      6'd39: c = 24'hA020F0;
      6'd40: c = 24'h101010;
      6'd41: c = 24'h202020;
      6'd42: c = 24'h303030;
      6'd43: c = 24'h404040;
      6'd44: c = 24'h505050;
      6'd45: c = 24'h606060;
      6'd46: c = 24'h70707A;
      6'd47: c = 24'h808080;
      6'd48: c = 24'h909090;
      6'd49: c = 24'hA0A0A0;
      6'd50: c = 24'hB0B0B0;
      6'd51: c = 24'hC0C0C0;
      6'd52: c = 24'hD0D0D0;
      6'd53: c = 24'hE0E0E0;
      6'd54: c = 24'hF0F0F0;
      6'd55: c = 24'hFFFFFF;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/nearest_palette_color_matcher.sv =====
// Top level of the nearest palette colour matcher: request sequencer, walk pipeline, output beat.
// Depends on nppc_pkg, nppc_store and nppc_dist.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    action, color_rgb, gray_percent, entry_index
//   out       output     out_valid/out_ready  palette_index, entry_rgb, was_appended,
//                                             palette_full, index_error
//   cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A find walks the palette through one read port and one distance unit; an exact match
// ends the walk early. Reads, gray ends and unused actions skip the walk.
// One request is in flight at a time; in_ready is high only in the idle state.
// A stalled output beat holds the sequencer until it is taken. Reset needs no clearing pass.
module nearest_palette_color_matcher
  import nppc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [RGB_W-1:0] color_rgb,
  input  logic [PCT_W-1:0] gray_percent,
  input  logic [IDX_W-1:0] entry_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] palette_index,
  output logic [RGB_W-1:0] entry_rgb,
  output logic             was_appended,
  output logic             palette_full,
  output logic             index_error,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [TOL_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_WALK   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_RDWAIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
    logic             app;
    logic             full;
    logic             err;
  } result_t;

  state_t            state, state_next;
  logic [1:0]        act_r;
  logic [RGB_W-1:0]  want;
  logic [PCT_W-1:0]  pct_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  count;
  logic [TOL_W-1:0]  tol;
  logic [IDX_W-1:0]  blk;
  logic [IDX_W-1:0]  wht;
  logic [CNT_W-1:0]  scan;
  logic              v1, v2;
  logic [IDX_W-1:0]  idx1, idx2;
  logic [RGB_W-1:0]  rgb2;
  logic              hit;
  logic [DIST_W-1:0] bestd;
  logic [IDX_W-1:0]  best_idx;
  logic [RGB_W-1:0]  best_rgb;

  store_req_t        sreq;
  logic [RGB_W-1:0]  rd_data;
  logic [DIST_W-1:0] dsum;

  logic [11:0]       p17;
  logic [24:0]       prod;
  logic [5:0]        gray_n;
  logic [CH_W-1:0]   gray_lv;
  logic              use_ans;
  logic [IDX_W-1:0]  ans;
  logic              issue;
  logic              fin;
  logic              load;
  logic              append;
  result_t           res;

  nppc_store u_store (
    .clk     (clk),
    .req     (sreq),
    .rd_data (rd_data)
  );

  nppc_dist u_dist (
    .clk  (clk),
    .en   (v1),
    .a    (want),
    .b    (rd_data),
    .dsum (dsum)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign issue     = (state == S_WALK) && !hit && (scan < count);

  // Percent to gray step: floor(pct * 17 / 100) through a reciprocal multiply.
  always_comb begin
    p17     = {1'b0, pct_r, 4'b0000} + 12'(pct_r);
    prod    = 25'(p17) * 25'd5243;
    gray_n  = prod[24:19];
    gray_lv = {gray_n[3:0], 4'b0000};
  end

  always_comb begin
    state_next = state;
    sreq       = '0;
    res        = '0;
    fin        = 1'b0;
    use_ans    = 1'b0;
    ans        = idx_r;
    append     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        case (act_r)
          ACT_FIND: state_next = S_WALK;
          ACT_GRAY: begin
            if (gray_n == 6'd0) begin
              use_ans = 1'b1;
              ans     = blk;
            end else if (gray_n >= 6'(GRAY_STEPS)) begin
              use_ans = 1'b1;
              ans     = wht;
            end else begin
              state_next = S_WALK;
            end
          end
          ACT_READ: begin
            use_ans = 1'b1;
            ans     = idx_r;
          end
          default: fin = 1'b1;
        endcase
        if (use_ans) begin
          if (CNT_W'(ans) < count) begin
            sreq.rd_en   = 1'b1;
            sreq.rd_addr = ans;
            state_next   = S_RDWAIT;
          end else begin
            fin     = 1'b1;
            res.idx = ans;
            res.err = 1'b1;
          end
        end
      end
      S_WALK: begin
        sreq.rd_en   = issue;
        sreq.rd_addr = scan[IDX_W-1:0];
        if (!issue && !v1 && !v2) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        fin = 1'b1;
        if (hit || bestd <= tol) begin
          res.idx = best_idx;
          res.rgb = best_rgb;
        end else if (count < CNT_W'(PAL_CAP)) begin
          append  = 1'b1;
          res.idx = count[IDX_W-1:0];
          res.rgb = want;
          res.app = 1'b1;
        end else begin
          res.idx  = best_idx;
          res.rgb  = best_rgb;
          res.full = 1'b1;
        end
      end
      S_RDWAIT: begin
        fin     = 1'b1;
        res.idx = best_idx;
        res.rgb = rd_data;
      end
      default: state_next = S_IDLE;
    endcase
    load         = fin && (!out_valid || out_ready);
    sreq.wr_en   = append && load;
    sreq.wr_addr = count[IDX_W-1:0];
    sreq.wr_data = want;
    if (load) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= CNT_W'(DEF_COUNT);
      tol       <= TOL_W'(3);
      blk       <= IDX_W'(1);
      wht       <= IDX_W'(0);
      v1        <= 1'b0;
      v2        <= 1'b0;
      hit       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TOL:   tol <= cfg_data;
          CFG_BLACK: blk <= cfg_data[IDX_W-1:0];
          CFG_WHITE: wht <= cfg_data[IDX_W-1:0];
          default:   ;
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (sreq.wr_en) begin
        count <= count + 1'b1;
      end
      if (state == S_START) begin
        hit <= 1'b0;
        v1  <= 1'b0;
        v2  <= 1'b0;
      end else if (state == S_WALK) begin
        v1 <= issue;
        v2 <= v1;
        if (v2 && !hit && dsum == '0) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      act_r <= action;
      want  <= color_rgb;
      pct_r <= gray_percent;
      idx_r <= entry_index;
    end
    if (state == S_START) begin
      scan     <= '0;
      bestd    <= DIST_START;
      best_idx <= ans;
      if (act_r == ACT_GRAY) begin
        want <= {gray_lv, gray_lv, gray_lv};
      end
    end else if (state == S_WALK) begin
      if (issue) begin
        scan <= scan + 1'b1;
      end
      idx1 <= scan[IDX_W-1:0];
      idx2 <= idx1;
      rgb2 <= rd_data;
      if (v2 && !hit) begin
        if (dsum == '0 || dsum < bestd) begin
          bestd    <= dsum;
          best_idx <= idx2;
          best_rgb <= rgb2;
        end
      end
    end
    if (load) begin
      palette_index <= res.idx;
      entry_rgb     <= res.rgb;
      was_appended  <= res.app;
      palette_full  <= res.full;
      index_error   <= res.err;
    end
  end

endmodule

// ===== hdl/nppc_store.sv =====
// Palette storage: a RAM for appended entries and the constant table for the default colours.
// Depends on nppc_pkg; the read data is registered.
module nppc_store
  import nppc_pkg::*;
(
  input  logic             clk,
  input  store_req_t       req,
  output logic [RGB_W-1:0] rd_data
);

  logic [RGB_W-1:0] mem [PAL_CAP];
  logic [RGB_W-1:0] ram_q;
  logic [RGB_W-1:0] rom_q;
  logic             rom_sel;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      ram_q   <= mem[req.rd_addr];
      rom_q   <= default_color(req.rd_addr[DEF_W-1:0]);
      rom_sel <= (CNT_W'(req.rd_addr) < CNT_W'(DEF_COUNT));
    end
  end

  assign rd_data = rom_sel ? rom_q : ram_q;

endmodule

// ===== hdl/nppc_dist.sv =====
// Shared distance unit: registered Manhattan distance between two packed RGB colours.
// Depends on nppc_pkg.
module nppc_dist
  import nppc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RGB_W-1:0]  a,
  input  logic [RGB_W-1:0]  b,
  output logic [DIST_W-1:0] dsum
);

  logic [CH_W-1:0] d_r;
  logic [CH_W-1:0] d_g;
  logic [CH_W-1:0] d_b;

  always_comb begin
    d_r = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    d_g = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
    d_b = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsum <= DIST_W'(d_r) + DIST_W'(d_g) + DIST_W'(d_b);
    end
  end

endmodule

// ===== hdl/nppc_checker.sv =====
// Port-level checker for the nearest palette colour matcher, bound to the top level.
// Depends on nppc_pkg and on the top level's ports.
module nppc_checker
  import nppc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] palette_index,
  input logic [RGB_W-1:0] entry_rgb,
  input logic             was_appended,
  input logic             palette_full,
  input logic             index_error
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(palette_index) && $stable(entry_rgb))
    else $error("output beat changed while stalled");

  // Requests are taken one at a time, so an accepted beat always drops ready.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request was in flight");

  a_append_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_appended |-> !palette_full && !index_error)
    else $error("appended beat carries an error flag");

  a_error_zero_rgb: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> entry_rgb == '0 && !was_appended && !palette_full)
    else $error("index error beat carries colour or find flags");

endmodule

bind nearest_palette_color_matcher nppc_checker u_nppc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .palette_index (palette_index),
  .entry_rgb     (entry_rgb),
  .was_appended  (was_appended),
  .palette_full  (palette_full),
  .index_error   (index_error)
);
